@@ rtl/core/spt_pkg.sv @@
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and codes for the segment and page translator.
// ----------------------------------------------------------------------------
package spt_pkg;

  // Configuration port address width: seven 32-bit registers at 4*i
  localparam int unsigned ApbAddrW = 5;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_PROT_MODE      = 3'd0;
  localparam logic [2:0] REG_PAGING_ENABLE  = 3'd1;
  localparam logic [2:0] REG_PAGE_DIR_BASE  = 3'd2;
  localparam logic [2:0] REG_GDT_BASE       = 3'd3;
  localparam logic [2:0] REG_GDT_LIMIT      = 3'd4;
  localparam logic [2:0] REG_LDT_BASE       = 3'd5;
  localparam logic [2:0] REG_LDT_LIMIT      = 3'd6;

  // Input beat kinds
  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_RESPONSE  = 1'b1;

  // Result kinds
  localparam logic [1:0] RK_READ  = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_FAULT = 2'd2;

  // Fault causes
  localparam logic [2:0] FC_NONE        = 3'd0;
  localparam logic [2:0] FC_LIMIT       = 3'd1;
  localparam logic [2:0] FC_SEG_ABSENT  = 3'd2;
  localparam logic [2:0] FC_PRIVILEGE   = 3'd3;
  localparam logic [2:0] FC_DIR_ABSENT  = 3'd4;
  localparam logic [2:0] FC_TAB_ABSENT  = 3'd5;

  // Descriptor tables are mapped high when paging is on
  localparam logic [31:0] HIGH_MAP = 32'hC000_0000;

  typedef struct packed {
    logic        prot_mode;
    logic        paging_enable;
    logic [19:0] page_dir_base;
    logic [31:0] gdt_base;
    logic [15:0] gdt_limit;
    logic [31:0] ldt_base;
    logic [15:0] ldt_limit;
  } spt_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] offset_address;
    logic [15:0] selector;
    logic [31:0] read_data;
  } spt_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] out_address;
    logic [2:0]  fault_cause;
  } spt_result_t;

endpackage

@@ rtl/core/spt_item_if.sv @@
// ----------------------------------------------------------------------------
// spt_item_if
// Input channel: translate requests and memory read response words.
// ----------------------------------------------------------------------------
interface spt_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] offset_address;
  logic [15:0] selector;
  logic [31:0] read_data;

  modport source (output valid, kind, offset_address, selector, read_data, input ready);
  modport sink   (input valid, kind, offset_address, selector, read_data, output ready);
endinterface

@@ rtl/core/spt_result_if.sv @@
// ----------------------------------------------------------------------------
// spt_result_if
// Output channel: read requests, finished translations and faults.
// ----------------------------------------------------------------------------
interface spt_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] out_address;
  logic [2:0]  fault_cause;

  modport source (output valid, result_kind, out_address, fault_cause, input ready);
  modport sink   (input valid, result_kind, out_address, fault_cause, output ready);
endinterface

@@ rtl/core/spt_regs.sv @@
// ----------------------------------------------------------------------------
// spt_regs
// APB-style configuration register file for the translator.
// ----------------------------------------------------------------------------
module spt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spt_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output spt_pkg::spt_cfg_t             cfg
);
  import spt_pkg::*;

  logic       wr_en;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_PROT_MODE:      cfg.prot_mode      <= pwdata[0];
        REG_PAGING_ENABLE:  cfg.paging_enable  <= pwdata[0];
        REG_PAGE_DIR_BASE:  cfg.page_dir_base  <= pwdata[19:0];
        REG_GDT_BASE:       cfg.gdt_base       <= pwdata;
        REG_GDT_LIMIT:      cfg.gdt_limit      <= pwdata[15:0];
        REG_LDT_BASE:       cfg.ldt_base       <= pwdata;
        REG_LDT_LIMIT:      cfg.ldt_limit      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_index)
      REG_PROT_MODE:      prdata = {31'd0, cfg.prot_mode};
      REG_PAGING_ENABLE:  prdata = {31'd0, cfg.paging_enable};
      REG_PAGE_DIR_BASE:  prdata = {12'd0, cfg.page_dir_base};
      REG_GDT_BASE:       prdata = cfg.gdt_base;
      REG_GDT_LIMIT:      prdata = {16'd0, cfg.gdt_limit};
      REG_LDT_BASE:       prdata = cfg.ldt_base;
      REG_LDT_LIMIT:      prdata = {16'd0, cfg.ldt_limit};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/spt_walk.sv @@
// ----------------------------------------------------------------------------
// spt_walk
// Translation sequencer: walk state plus the single-step next-state logic.
// ----------------------------------------------------------------------------
module spt_walk (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  spt_pkg::spt_item_t   item,
  input  spt_pkg::spt_cfg_t    cfg,
  output logic                 emit,
  output spt_pkg::spt_result_t result
);
  import spt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DESC_LO = 3'd1,
    PH_DESC_HI = 3'd2,
    PH_PDE     = 3'd3,
    PH_PTE     = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] held_offset, held_offset_next;
  logic [31:0] held_linear, held_linear_next;
  logic [31:0] descriptor_low, descriptor_low_next;
  logic [1:0]  held_rpl, held_rpl_next;
  logic [31:0] table_base, table_base_next;

  // Shared decode of the current beat
  logic [12:0] sel_index;
  logic [31:0] sel_base;
  logic [15:0] sel_limit;
  logic [31:0] seg_base;
  logic [31:0] seg_linear;
  logic        walk_on;

  assign sel_index  = item.selector[15:3];
  assign sel_base   = item.selector[2] ? cfg.ldt_base : cfg.gdt_base;
  assign sel_limit  = item.selector[2] ? cfg.ldt_limit : cfg.gdt_limit;
  assign seg_base   = {item.read_data[31:24], item.read_data[7:0], descriptor_low[31:16]};
  assign seg_linear = held_offset + seg_base;
  assign walk_on    = cfg.prot_mode && cfg.paging_enable;

  // Compute next state and the result for one beat
  always_comb begin
    phase_next          = phase;
    held_offset_next    = held_offset;
    held_linear_next    = held_linear;
    descriptor_low_next = descriptor_low;
    held_rpl_next       = held_rpl;
    table_base_next     = table_base;
    emit                = 1'b0;
    result              = '{result_kind: RK_FAULT, out_address: '0, fault_cause: FC_NONE};

    if (item.kind == KIND_TRANSLATE) begin
      held_offset_next = item.offset_address;
      held_rpl_next    = item.selector[1:0];
      emit             = 1'b1;
      if (!cfg.prot_mode || item.selector == 16'd0) begin
        // Flat mode or null selector: linear is the offset
        held_linear_next = item.offset_address;
        if (walk_on) begin
          phase_next         = PH_PDE;
          result.result_kind = RK_READ;
          result.out_address = {cfg.page_dir_base, item.offset_address[31:22], 2'b00};
        end else begin
          phase_next         = PH_IDLE;
          result.result_kind = RK_DONE;
          result.out_address = item.offset_address;
        end
      end else if ({3'd0, sel_index} > sel_limit) begin
        phase_next         = PH_IDLE;
        result.fault_cause = FC_LIMIT;
      end else begin
        // Fetch the descriptor low word
        table_base_next    = (cfg.paging_enable ? (sel_base | HIGH_MAP) : sel_base)
                             + {16'd0, sel_index, 3'b000};
        phase_next         = PH_DESC_LO;
        result.result_kind = RK_READ;
        result.out_address = table_base_next;
      end
    end else begin
      case (phase)
        PH_DESC_LO: begin
          descriptor_low_next = item.read_data;
          phase_next          = PH_DESC_HI;
          emit                = 1'b1;
          result.result_kind  = RK_READ;
          result.out_address  = table_base + 32'd4;
        end
        PH_DESC_HI: begin
          emit = 1'b1;
          if (!item.read_data[15]) begin
            phase_next         = PH_IDLE;
            result.fault_cause = FC_SEG_ABSENT;
          end else if (held_rpl > item.read_data[14:13]) begin
            phase_next         = PH_IDLE;
            result.fault_cause = FC_PRIVILEGE;
          end else begin
            held_linear_next = seg_linear;
            if (walk_on) begin
              phase_next         = PH_PDE;
              result.result_kind = RK_READ;
              result.out_address = {cfg.page_dir_base, seg_linear[31:22], 2'b00};
            end else begin
              phase_next         = PH_IDLE;
              result.result_kind = RK_DONE;
              result.out_address = seg_linear;
            end
          end
        end
        PH_PDE: begin
          emit = 1'b1;
          if (!item.read_data[0]) begin
            phase_next         = PH_IDLE;
            result.fault_cause = FC_DIR_ABSENT;
          end else begin
            phase_next         = PH_PTE;
            result.result_kind = RK_READ;
            result.out_address = {item.read_data[31:12], held_linear[21:12], 2'b00};
          end
        end
        PH_PTE: begin
          emit       = 1'b1;
          phase_next = PH_IDLE;
          if (!item.read_data[0]) begin
            result.fault_cause = FC_TAB_ABSENT;
          end else begin
            result.result_kind = RK_DONE;
            result.out_address = {item.read_data[31:12], held_linear[11:0]};
          end
        end
        default: begin
          // Stray response while idle: drop it
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Advance the walk state on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      held_offset    <= '0;
      held_linear    <= '0;
      descriptor_low <= '0;
      held_rpl       <= '0;
      table_base     <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      held_offset    <= held_offset_next;
      held_linear    <= held_linear_next;
      descriptor_low <= descriptor_low_next;
      held_rpl       <= held_rpl_next;
      table_base     <= table_base_next;
    end
  end

endmodule

@@ rtl/core/segment_and_page_translator.sv @@
// ----------------------------------------------------------------------------
// segment_and_page_translator
// Protected-mode segment translation with a two-level page walk.
// ----------------------------------------------------------------------------
// Each beat on the item channel lands in an input register, one step of the
// walk is computed from it and the walk state, and the result (read request,
// finished address or fault) is loaded into the result register, so a new
// beat is accepted every cycle while no result stalls; its result is valid on
// the port once loaded into the result register. The result register is the
// only stall point: while it holds an untaken result, the beat in the input
// register waits, even a response beat that arrives while idle and is dropped
// without a result. Memory reads go out as results; their words come back as
// response beats in the order the reads were issued. A request beat aborts
// any walk in progress.
module segment_and_page_translator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spt_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  spt_item_if.sink                      item,
  spt_result_if.source                  result
);
  import spt_pkg::*;

  spt_cfg_t    cfg;
  spt_item_t   item_q;
  logic        item_valid;
  spt_result_t step_result;
  logic        step_emit;
  logic        fire;
  logic        result_valid;
  spt_result_t result_q;

  spt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Process the held beat when the result register can take its output
  assign fire       = item_valid && (!result_valid || result.ready);
  assign item.ready = !item_valid || fire;

  // Input register: load a new beat, drop the processed one
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q <= '{kind: item.kind, offset_address: item.offset_address,
                  selector: item.selector, read_data: item.read_data};
    end
  end

  spt_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .cfg    (cfg),
    .emit   (step_emit),
    .result (step_result)
  );

  // Result register: hold until the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= step_emit;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_emit) begin
      result_q <= step_result;
    end
  end

  assign result.valid       = result_valid;
  assign result.result_kind = result_q.result_kind;
  assign result.out_address = result_q.out_address;
  assign result.fault_cause = result_q.fault_cause;

endmodule
